>>> hw/rtl/gekd_pkg.sv
// shared constants, types and command/status structs for the gyro filter
`timescale 1ns / 1ps
package gekd_pkg;
   localparam int FRACTION_BITS_DEF = 8;
   localparam int ST_W = 20;
   localparam int P_W = 24;
   localparam int IN_W = 16;
   localparam int CSR_W = 19;
   localparam int CSR_IDX_W = 3;
   localparam logic [P_W-1:0] P_RESET = 24'd8388608;
   localparam logic [P_W-1:0] KQ = 24'd8389;
   localparam logic [P_W-1:0] KR = 24'd251658;
   localparam logic [2:0] REG_WEIGHT = 3'd0;
   localparam logic [2:0] REG_DEAD = 3'd1;
   localparam logic [2:0] REG_THRESH = 3'd2;
   localparam logic [2:0] REG_GAIN = 3'd3;
   localparam logic [2:0] REG_BIAS_X = 3'd4;
   localparam logic [2:0] REG_BIAS_Y = 3'd5;
   localparam logic [2:0] REG_BIAS_Z = 3'd6;

   typedef enum logic [3:0] {
      OP_NONE, OP_LOAD, OP_DIV_START, OP_DIV_STEP, OP_CONV, OP_EMA, OP_KALMAN,
      OP_SHAPE, OP_COV, OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic [1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;
endpackage

>>> hw/rtl/gekd_stream_if.sv
// valid/ready channel carrying a three-axis word
`timescale 1ns / 1ps
interface gekd_stream_if #(parameter int W = 16);
   logic valid;
   logic ready;
   logic signed [W-1:0] x;
   logic signed [W-1:0] y;
   logic signed [W-1:0] z;
   modport source(output valid, x, y, z, input ready);
   modport sink(input valid, x, y, z, output ready);
endinterface

>>> hw/rtl/gekd_ctrl.sv
// sequencer stepping the datapath through one sample
`timescale 1ns / 1ps
module gekd_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic in_fire,
   input  logic out_free,
   input  gekd_pkg::status_type status,
   output gekd_pkg::cmd_type cmd,
   output logic busy
);
   typedef enum logic [3:0] {
      S_IDLE, S_DSTART, S_DIV, S_CONV, S_EMA, S_KALMAN, S_SHAPE, S_COV, S_WAIT
   } state_type;
   state_type state_ff;
   logic [1:0] axis_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         axis_ff <= 2'd0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (in_fire) state_ff <= S_DSTART;
            S_DSTART: state_ff <= S_DIV;
            S_DIV: if (status.div_done) begin
               state_ff <= S_CONV;
               axis_ff <= 2'd0;
            end
            S_CONV: state_ff <= S_EMA;
            S_EMA: state_ff <= S_KALMAN;
            S_KALMAN: state_ff <= S_SHAPE;
            S_SHAPE: begin
               if (axis_ff == 2'd2) begin
                  state_ff <= S_COV;
                  axis_ff <= 2'd0;
               end else begin
                  state_ff <= S_CONV;
                  axis_ff <= axis_ff + 2'd1;
               end
            end
            S_COV: state_ff <= S_WAIT;
            S_WAIT: if (out_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.axis = axis_ff;
      unique case (state_ff)
         S_IDLE: cmd.op = in_fire ? gekd_pkg::OP_LOAD : gekd_pkg::OP_NONE;
         S_DSTART: cmd.op = gekd_pkg::OP_DIV_START;
         S_DIV: cmd.op = gekd_pkg::OP_DIV_STEP;
         S_CONV: cmd.op = gekd_pkg::OP_CONV;
         S_EMA: cmd.op = gekd_pkg::OP_EMA;
         S_KALMAN: cmd.op = gekd_pkg::OP_KALMAN;
         S_SHAPE: cmd.op = gekd_pkg::OP_SHAPE;
         S_COV: cmd.op = gekd_pkg::OP_COV;
         S_WAIT: cmd.op = out_free ? gekd_pkg::OP_OUT : gekd_pkg::OP_NONE;
         default: cmd.op = gekd_pkg::OP_NONE;
      endcase
   end
   assign busy = (state_ff != S_IDLE);
endmodule

>>> hw/rtl/gekd_datapath.sv
// per-axis arithmetic, kalman gain divider and state registers
`timescale 1ns / 1ps
module gekd_datapath #(
   parameter int FRACTION_BITS = gekd_pkg::FRACTION_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  gekd_pkg::cmd_type cmd,
   output gekd_pkg::status_type status,
   input  logic signed [15:0] raw_x,
   input  logic signed [15:0] raw_y,
   input  logic signed [15:0] raw_z,
   input  logic [16:0] weight,
   input  logic [18:0] dead_band,
   input  logic [18:0] thresh,
   input  logic [11:0] gain,
   input  logic signed [17:0] bias_x,
   input  logic signed [17:0] bias_y,
   input  logic signed [17:0] bias_z,
   output logic signed [19:0] res_x,
   output logic signed [19:0] res_y,
   output logic signed [19:0] res_z
);
   localparam longint LIM_RAW = 2047 * (64'sd1 <<< FRACTION_BITS);
   localparam logic [24:0] LIM = (LIM_RAW > 524287) ? 25'd524287 : 25'(LIM_RAW);
   // reciprocal of 131 scaled by 2^37, exact for halved numerators below 2^29
   localparam logic [29:0] RECIP = 30'(((64'd1 << 37) + 64'd130) / 64'd131);

   logic signed [15:0] raw_ff [3];
   logic signed [19:0] sm_ff [3];
   logic signed [19:0] est_ff [3];
   logic signed [19:0] res_ff [3];
   logic signed [19:0] c_ff;
   logic [23:0] p_ff;
   logic [24:0] pp_ff;
   logic [25:0] den_ff;
   logic [49:0] rem_ff;
   logic [23:0] k_ff;
   logic [5:0] cnt_ff;

   // restoring divider, one quotient bit a cycle
   logic [25:0] trial;
   logic [49:0] rem_in;
   always_comb begin
      rem_in = {rem_ff[48:0], 1'b0};
      trial = rem_in[49:24] - den_ff;
   end
   assign status.div_done = (cnt_ff == 6'd0);

   logic signed [15:0] raw_s;
   logic signed [17:0] bias_s;
   logic [15:0] mag_r;
   logic [29:0] num;
   logic [58:0] prod_q;
   logic signed [22:0] q_s;
   logic signed [23:0] c_wide;
   logic signed [19:0] c_n;
   logic [16:0] w_eff;
   logic signed [20:0] diff_e;
   logic signed [38:0] prod_e;
   logic signed [23:0] e_wide;
   logic signed [19:0] sm_n;
   logic signed [20:0] diff_k;
   logic signed [45:0] prod_k;
   logic signed [24:0] x_wide;
   logic signed [19:0] est_n;
   logic signed [19:0] v_s;
   logic [19:0] mag_v, over_db;
   logic [32:0] boost;
   logic [24:0] m_b;
   logic [18:0] m_out;
   logic signed [19:0] out_n;
   always_comb begin
      // conversion to dps, bias removal and clamp
      raw_s = raw_ff[cmd.axis];
      unique case (cmd.axis)
         2'd0: bias_s = bias_x;
         2'd1: bias_s = bias_y;
         default: bias_s = bias_z;
      endcase
      mag_r = raw_s[15] ? $unsigned(-raw_s) : $unsigned(raw_s);
      num = (30'(mag_r) << (FRACTION_BITS + 2)) + 30'd131;
      // divide by 262 as a halving then a multiply by the reciprocal of 131
      prod_q = num[29:1] * RECIP;
      q_s = raw_s[15] ? -$signed({1'b0, prod_q[58:37]}) : $signed({1'b0, prod_q[58:37]});
      c_wide = 24'(q_s) - 24'(bias_s);
      if (c_wide > 24'sd524287) c_n = 20'sh7FFFF;
      else if (c_wide < -24'sd524288) c_n = 20'sh80000;
      else c_n = c_wide[19:0];

      // ema written as previous plus weighted step
      w_eff = (weight > 17'd65536) ? 17'd65536 : weight;
      diff_e = 21'(c_ff) - 21'(sm_ff[cmd.axis]);
      prod_e = $signed({1'b0, w_eff}) * diff_e;
      e_wide = 24'(sm_ff[cmd.axis]) + 24'((prod_e + 39'sd32768) >>> 16);
      if (e_wide > 24'sd524287) sm_n = 20'sh7FFFF;
      else if (e_wide < -24'sd524288) sm_n = 20'sh80000;
      else sm_n = e_wide[19:0];

      // kalman update
      diff_k = 21'(sm_ff[cmd.axis]) - 21'(est_ff[cmd.axis]);
      prod_k = $signed({1'b0, k_ff}) * diff_k;
      x_wide = 25'(est_ff[cmd.axis]) + 25'((prod_k + 46'sd4194304) >>> 23);
      if (x_wide > 25'sd524287) est_n = 20'sh7FFFF;
      else if (x_wide < -25'sd524288) est_n = 20'sh80000;
      else est_n = x_wide[19:0];

      // dead zone and boost on the magnitude
      v_s = est_ff[cmd.axis];
      mag_v = v_s[19] ? $unsigned(-v_s) : $unsigned(v_s);
      over_db = mag_v - 20'(dead_band);
      boost = (over_db - 20'(thresh)) * gain + 33'd128;
      if (over_db > 20'(thresh)) m_b = 25'(thresh) + boost[32:8];
      else m_b = 25'(over_db);
      if (m_b > LIM) m_b = LIM;
      m_out = m_b[18:0];
      if (mag_v <= 20'(dead_band)) out_n = '0;
      else if (v_s[19]) out_n = -$signed({1'b0, m_out});
      else out_n = $signed({1'b0, m_out});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= gekd_pkg::P_RESET;
         cnt_ff <= 6'd0;
         for (int i = 0; i < 3; i++) begin
            sm_ff[i] <= '0;
            est_ff[i] <= '0;
         end
      end else begin
         unique case (cmd.op)
            gekd_pkg::OP_LOAD: begin
               raw_ff[0] <= raw_x;
               raw_ff[1] <= raw_y;
               raw_ff[2] <= raw_z;
               pp_ff <= {1'b0, p_ff} + {1'b0, gekd_pkg::KQ};
            end
            gekd_pkg::OP_DIV_START: begin
               den_ff <= {1'b0, pp_ff} + {2'b0, gekd_pkg::KR};
               // numerator pp*2^23 + den/2, scaled into the remainder window
               rem_ff <= 50'({pp_ff, 23'd0}) + 50'((26'({1'b0, pp_ff})
                         + 26'(gekd_pkg::KR)) >> 1);
               k_ff <= '0;
               cnt_ff <= 6'd24;
            end
            gekd_pkg::OP_DIV_STEP: if (cnt_ff != 0) begin
               cnt_ff <= cnt_ff - 6'd1;
               if (rem_in[49:24] >= den_ff) begin
                  rem_ff <= {trial, rem_in[23:0]};
                  k_ff <= {k_ff[22:0], 1'b1};
               end else begin
                  rem_ff <= rem_in;
                  k_ff <= {k_ff[22:0], 1'b0};
               end
            end
            gekd_pkg::OP_CONV: c_ff <= c_n;
            gekd_pkg::OP_EMA: sm_ff[cmd.axis] <= sm_n;
            gekd_pkg::OP_KALMAN: est_ff[cmd.axis] <= est_n;
            gekd_pkg::OP_SHAPE: res_ff[cmd.axis] <= out_n;
            gekd_pkg::OP_COV: p_ff <= 24'((((49'd8388608 - 49'(k_ff)) * 49'(pp_ff))
                                         + 49'd4194304) >> 23);
            default: ;
         endcase
      end
   end
   assign res_x = res_ff[0];
   assign res_y = res_ff[1];
   assign res_z = res_ff[2];
endmodule

>>> hw/rtl/gyro_ema_kalman_deadzone_filter_core.sv
// one word in flight: a new word is accepted only once the last has reached the output register
// each word passes through load, the bit-serial kalman gain divider,
// four steps per axis on the shared datapath, covariance update and output hand-off
// a result word still waiting holds the sequencer until the output register frees
// synchronous active-high reset: registers to defaults, filter state zero, covariance one
`timescale 1ns / 1ps
module gyro_ema_kalman_deadzone_filter_core #(
   parameter int FRACTION_BITS = gekd_pkg::FRACTION_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   gekd_stream_if.sink req,
   gekd_stream_if.source rsp,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [18:0] csr_data
);
   logic [16:0] weight_ff;
   logic [18:0] dead_ff, thr_ff;
   logic [11:0] gain_ff;
   logic signed [17:0] bx_ff, by_ff, bz_ff;
   logic rsp_valid_ff, busy;
   gekd_pkg::cmd_type cmd;
   gekd_pkg::status_type status;
   logic signed [19:0] rx, ry, rz;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= 17'd19661;
         dead_ff <= 19'd512;
         thr_ff <= 19'd6400;
         gain_ff <= 12'd614;
         bx_ff <= '0; by_ff <= '0; bz_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            gekd_pkg::REG_WEIGHT: weight_ff <= csr_data[16:0];
            gekd_pkg::REG_DEAD: dead_ff <= csr_data;
            gekd_pkg::REG_THRESH: thr_ff <= csr_data;
            gekd_pkg::REG_GAIN: gain_ff <= csr_data[11:0];
            gekd_pkg::REG_BIAS_X: bx_ff <= csr_data[17:0];
            gekd_pkg::REG_BIAS_Y: by_ff <= csr_data[17:0];
            gekd_pkg::REG_BIAS_Z: bz_ff <= csr_data[17:0];
            default: ;
         endcase
      end
   end

   logic out_free;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = !busy;

   gekd_ctrl u_ctrl (.clock, .reset, .in_fire(req.valid && !busy), .out_free,
                     .status, .cmd, .busy);
   gekd_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
      .clock, .reset, .cmd, .status, .raw_x(req.x), .raw_y(req.y), .raw_z(req.z),
      .weight(weight_ff), .dead_band(dead_ff), .thresh(thr_ff), .gain(gain_ff),
      .bias_x(bx_ff), .bias_y(by_ff), .bias_z(bz_ff), .res_x(rx), .res_y(ry), .res_z(rz));

   logic signed [19:0] ox_ff, oy_ff, oz_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.op == gekd_pkg::OP_OUT) rsp_valid_ff <= 1'b1;
      else if (rsp.ready) rsp_valid_ff <= 1'b0;
      if (cmd.op == gekd_pkg::OP_OUT) begin
         ox_ff <= rx; oy_ff <= ry; oz_ff <= rz;
      end
   end
   assign rsp.valid = rsp_valid_ff;
   assign rsp.x = ox_ff;
   assign rsp.y = oy_ff;
   assign rsp.z = oz_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !req.ready) else $error("accepted word while busy");
   a_out_after_work: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == gekd_pkg::OP_OUT) |=> rsp.valid) else $error("result lost");
`endif
endmodule

>>> verif/testbench.sv
// self-checking testbench for the gyro ema/kalman/dead-zone filter core
`timescale 1ns / 1ps
module testbench;
   localparam int FB = gekd_pkg::FRACTION_BITS_DEF;
   localparam longint ONE_Q23 = 64'd8388608;
   localparam longint ST_MAX = 524287;
   localparam longint ST_MIN = -524288;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 150;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic signed [gekd_pkg::ST_W-1:0] x;
      logic signed [gekd_pkg::ST_W-1:0] y;
      logic signed [gekd_pkg::ST_W-1:0] z;
   } motion_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [18:0] csr_data = '0;

   gekd_stream_if #(.W(gekd_pkg::IN_W)) req_if ();
   gekd_stream_if #(.W(gekd_pkg::ST_W)) rsp_if ();

   gyro_ema_kalman_deadzone_filter_core dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor copy of registers and filter state
   longint weight_q, dead_q, thresh_q, gain_q;
   longint bias_q[3];
   longint smooth_q[3], est_q[3], cov_q;

   motion_type motion_expected[$];
   bit failed = 1'b0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit recv_hold = 1'b0;
   int idle_run = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic longint round_shift(longint v, int n);
      longint t;
      t = v + (64'sd1 <<< (n - 1));
      if (t >= 0) return t >>> n;
      return -((-t + ((64'sd1 <<< n) - 1)) >>> n);
   endfunction

   function automatic longint clamp20(longint v);
      return v < ST_MIN ? ST_MIN : (v > ST_MAX ? ST_MAX : v);
   endfunction

   function automatic longint raw_to_dps(longint raw);
      longint mag, q;
      mag = raw < 0 ? -raw : raw;
      q = (mag * (64'sd1 <<< (FB + 2)) + 131) / 262;
      return raw < 0 ? -q : q;
   endfunction

   function automatic longint shape_rate(longint v);
      longint mag, lim;
      mag = v < 0 ? -v : v;
      lim = 64'sd2047 <<< FB;
      if (lim > ST_MAX) lim = ST_MAX;
      if (mag <= dead_q) return 0;
      mag -= dead_q;
      if (mag > thresh_q) mag = thresh_q + (((mag - thresh_q) * gain_q + 128) >>> 8);
      if (mag > lim) mag = lim;
      return v < 0 ? -mag : mag;
   endfunction

   task automatic predict_motion(input logic signed [gekd_pkg::IN_W-1:0] rx, ry, rz);
      longint w, pp, den, k, c, e;
      longint raw[3];
      longint res[3];
      motion_type m;
      raw[0] = longint'(rx); raw[1] = longint'(ry); raw[2] = longint'(rz);
      w = weight_q > 65536 ? 65536 : weight_q;
      pp = cov_q + 8389;
      den = pp + 251658;
      k = (pp * ONE_Q23 + den / 2) / den;
      for (int i = 0; i < 3; i++) begin
         c = clamp20(raw_to_dps(raw[i]) - bias_q[i]);
         e = round_shift(w * c + (65536 - w) * smooth_q[i], 16);
         smooth_q[i] = clamp20(e);
         est_q[i] = clamp20(est_q[i] + round_shift(k * (smooth_q[i] - est_q[i]), 23));
         res[i] = shape_rate(est_q[i]);
      end
      cov_q = ((((ONE_Q23 - k) * pp) + (64'sd1 <<< 22)) >>> 23) & 64'hFFFFFF;
      m.x = 20'(res[0]); m.y = 20'(res[1]); m.z = 20'(res[2]);
      motion_expected.push_back(m);
   endtask

   task automatic reset_model();
      weight_q = 19661; dead_q = 512; thresh_q = 6400; gain_q = 614;
      for (int i = 0; i < 3; i++) begin
         bias_q[i] = 0; smooth_q[i] = 0; est_q[i] = 0;
      end
      cov_q = ONE_Q23;
   endtask

   // only called while idle
   task automatic write_reg(input logic [2:0] idx, input logic [18:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         gekd_pkg::REG_WEIGHT: weight_q = longint'(val[16:0]);
         gekd_pkg::REG_DEAD: dead_q = longint'(val);
         gekd_pkg::REG_THRESH: thresh_q = longint'(val);
         gekd_pkg::REG_GAIN: gain_q = longint'(val[11:0]);
         gekd_pkg::REG_BIAS_X: bias_q[0] = longint'($signed(val[17:0]));
         gekd_pkg::REG_BIAS_Y: bias_q[1] = longint'($signed(val[17:0]));
         gekd_pkg::REG_BIAS_Z: bias_q[2] = longint'($signed(val[17:0]));
         default: ;
      endcase
      @(posedge clock);
   endtask

   // valid stays up after acceptance until the next idle cycle or drain
   task automatic send_word(input logic signed [gekd_pkg::IN_W-1:0] rx, ry, rz);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1; req_if.x <= rx; req_if.y <= ry; req_if.z <= rz;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_motion(rx, ry, rz);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (motion_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [gekd_pkg::IN_W-1:0] pick_raw();
      case ($urandom_range(5, 0))
         0: return 16'($urandom_range(65535, 0));
         1: return 16'($urandom_range(65535, 32768));
         2: return 16'($urandom_range(32767, 32000));
         default: return $signed(16'($urandom_range(3000, 0))) - 16'sd1500;
      endcase
   endfunction

   task automatic send_random(input int n);
      for (int i = 0; i < n; i++) send_word(pick_raw(), pick_raw(), pick_raw());
   endtask

   task automatic test_directed();
      send_word(16'sh7FFF, -16'sh8000, 16'sd0);
      send_word(-16'sh8000, 16'sh7FFF, 16'sd1);
      send_word(16'sd0, 16'sd0, 16'sd0);
      send_word(-16'sd1, 16'sd66, -16'sd131);
      send_word(16'sd3, -16'sd3, 16'sd65);
      for (int i = 0; i < 6; i++) send_word(16'sh7FFF, 16'sh7FFF, -16'sh8000);
      wait_drained();
      // weight above one and zero weight
      write_reg(gekd_pkg::REG_WEIGHT, 19'd131071);
      send_word(16'sd1000, -16'sd1000, 16'sh5555);
      send_word(-16'sh2AAB, 16'sd5, 16'sd0);
      wait_drained();
      write_reg(gekd_pkg::REG_WEIGHT, 19'd0);
      send_word(16'sd4000, 16'sd4000, 16'sd4000);
      wait_drained();
      // bias extremes on x and y and a bias of minus one on z
      write_reg(gekd_pkg::REG_WEIGHT, 19'd65536);
      write_reg(gekd_pkg::REG_BIAS_X, 19'h20000);
      write_reg(gekd_pkg::REG_BIAS_Y, 19'h1FFFF);
      write_reg(gekd_pkg::REG_BIAS_Z, 19'h7FFFF);
      for (int i = 0; i < 4; i++) send_word(16'sh7FFF, -16'sh8000, 16'sd100);
      wait_drained();
      // dead band, threshold and gain extremes
      write_reg(gekd_pkg::REG_DEAD, 19'd0);
      write_reg(gekd_pkg::REG_THRESH, 19'd0);
      write_reg(gekd_pkg::REG_GAIN, 19'd4095);
      send_word(16'sd10, -16'sd10, 16'sd300);
      send_word(16'sd2, -16'sd2000, 16'sd0);
      wait_drained();
      write_reg(gekd_pkg::REG_DEAD, 19'h7FFFF);
      write_reg(gekd_pkg::REG_THRESH, 19'h7FFFF);
      write_reg(gekd_pkg::REG_GAIN, 19'd0);
      send_word(16'sh7FFF, -16'sh8000, 16'sd1);
      wait_drained();
      // unused index must be ignored
      write_reg(REG_UNUSED, 19'h7FFFF);
   endtask

   task automatic test_settings();
      logic [18:0] dz[4] = '{19'd0, 19'd512, 19'd2000, 19'h7FFFF};
      for (int p = 0; p < 4; p++) begin
         wait_drained();
         write_reg(gekd_pkg::REG_WEIGHT,
                   p == 3 ? 19'd65536 : 19'($urandom_range(70000, 0)));
         write_reg(gekd_pkg::REG_DEAD, p == 3 ? dz[$urandom_range(2, 0)] : dz[p]);
         write_reg(gekd_pkg::REG_THRESH, 19'($urandom_range(20000, 0)));
         write_reg(gekd_pkg::REG_GAIN, 19'($urandom_range(4095, 0)));
         write_reg(gekd_pkg::REG_BIAS_X, 19'($urandom_range(262143, 0)));
         write_reg(gekd_pkg::REG_BIAS_Y, 19'($urandom_range(1000, 0)));
         write_reg(gekd_pkg::REG_BIAS_Z, 19'd0);
         send_random(40);
      end
      wait_drained();
      write_reg(gekd_pkg::REG_WEIGHT, 19'd19661);
      write_reg(gekd_pkg::REG_DEAD, 19'd512);
      write_reg(gekd_pkg::REG_THRESH, 19'd6400);
      write_reg(gekd_pkg::REG_GAIN, 19'd614);
      write_reg(gekd_pkg::REG_BIAS_X, 19'd0);
      write_reg(gekd_pkg::REG_BIAS_Y, 19'd0);
   endtask

   task automatic test_idling();
      send_idle_pct = 0; recv_stall_pct = 0; send_random(160);
      send_idle_pct = 77; send_random(80);
      send_idle_pct = 0; recv_stall_pct = 77; send_random(80);
      send_idle_pct = 8; recv_stall_pct = 8; send_random(80);
      send_idle_pct = 0; recv_stall_pct = 0;
   endtask

   task automatic test_backpressure();
      recv_hold = 1'b1;
      fork
         begin
            repeat (600) @(posedge clock);
            recv_hold = 1'b0;
         end
         send_random(8);
      join
      wait_drained();
      // sender waits for every result before the next word
      for (int i = 0; i < 10; i++) begin
         send_random(1);
         req_if.valid <= 1'b0;
         while (motion_expected.size() != 0) @(posedge clock);
      end
   endtask

   // receiver readiness
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !recv_hold &&
            !(recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
      end
   end

   // result checker
   always @(posedge clock) begin
      motion_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (motion_expected.size() == 0) begin
            $display("%0t unexpected word x=%0d y=%0d z=%0d", $time,
               rsp_if.x, rsp_if.y, rsp_if.z);
            failed = 1'b1;
         end else begin
            want = motion_expected.pop_front();
            if (want.x !== rsp_if.x) begin
               $display("%0t motion_x expected %0d actual %0d", $time, want.x, rsp_if.x);
               failed = 1'b1;
            end
            if (want.y !== rsp_if.y) begin
               $display("%0t motion_y expected %0d actual %0d", $time, want.y, rsp_if.y);
               failed = 1'b1;
            end
            if (want.z !== rsp_if.z) begin
               $display("%0t motion_z expected %0d actual %0d", $time, want.z, rsp_if.z);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset) begin
         idle_run <= 0;
      end else begin
         idle_run <= idle_run + 1;
         if (idle_run >= WATCHDOG_LIMIT) begin
            $display("gyro_ema_kalman_deadzone_filter_core: mismatch");
            $finish;
         end
      end
   end

   initial begin
      req_if.valid <= 1'b0; req_if.x <= '0; req_if.y <= '0; req_if.z <= '0;
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_settings();
      test_idling();
      test_backpressure();
      wait_drained();
      if (!failed && motion_expected.size() == 0) begin
         $display("gyro_ema_kalman_deadzone_filter_core: match");
      end else begin
         $display("gyro_ema_kalman_deadzone_filter_core: mismatch");
      end
      $finish;
   end
endmodule

>>> filelist.f
hw/rtl/gekd_pkg.sv
hw/rtl/gekd_stream_if.sv
hw/rtl/gekd_ctrl.sv
hw/rtl/gekd_datapath.sv
hw/rtl/gyro_ema_kalman_deadzone_filter_core.sv
verif/testbench.sv
